// ===== hw/rtl/isasum_pkg.sv =====
// ----------------------------------------------------------------------------
// isasum_pkg
// Shared codes, widths and the per-cycle control word that the top level
// broadcasts to every storage cell of the indexed shift array.
// ----------------------------------------------------------------------------
package isasum_pkg;

  // Fixed field widths of the command and result transactions.
  localparam int ACT_W   = 3;
  localparam int IDX_W   = 6;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;
  localparam int SUM_W   = 38;

  // Position width that covers every array depth the block supports (up to 1024).
  localparam int POS_W   = 11;

  // Command codes.
  localparam logic [ACT_W-1:0] ACT_READ     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DEL_LAST = 3'd5;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADIDX = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  // Cell operations.
  localparam logic [1:0] CELL_NONE   = 2'd0;
  localparam logic [1:0] CELL_WRITE  = 2'd1;
  localparam logic [1:0] CELL_INSERT = 2'd2;
  localparam logic [1:0] CELL_DELETE = 2'd3;

  // Control word seen by every cell in the same cycle.
  typedef struct packed {
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] limit;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/isasum_cell.sv =====
// ----------------------------------------------------------------------------
// isasum_cell
// One storage cell of the array. It holds a single entry, compares its own
// position with the broadcast control word and loads the command value, its
// left neighbor, its right neighbor or zero.
// ----------------------------------------------------------------------------
module isasum_cell import isasum_pkg::*; #(
  parameter int POS = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] sel_data
);

  localparam logic [POS_W-1:0] ME = POS_W'(POS);

  logic signed [DATA_W-1:0] data_next;

  // Next entry value from the broadcast operation and this cell's position.
  always_comb begin
    data_next = data;
    unique case (ctrl.op)
      CELL_WRITE: begin
        if (ME == ctrl.pos) begin
          data_next = value;
        end
      end
      CELL_INSERT: begin
        if (ME == ctrl.pos) begin
          data_next = value;
        end else if (ME > ctrl.pos && ME <= ctrl.limit) begin
          data_next = left_data;
        end
      end
      CELL_DELETE: begin
        if (ME == ctrl.limit) begin
          data_next = '0;
        end else if (ME >= ctrl.pos && ME < ctrl.limit) begin
          data_next = right_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  // Entry storage; reset clears it to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else begin
      data <= data_next;
    end
  end

  // Drive the entry onto the read bus only when this cell is addressed.
  assign sel_data = (ME == ctrl.pos) ? data : '0;

endmodule

// ===== hw/rtl/indexed_shift_array_with_sum.sv =====
// ----------------------------------------------------------------------------
// indexed_shift_array_with_sum
// Packed array of signed 32-bit entries with element count and running sum.
// ----------------------------------------------------------------------------
// Usage:
//   The command channel (in_valid/in_ready) carries action, index and value.
//   The result channel (out_valid/out_ready) returns status, read_value,
//   element_count and running_sum, one result transaction per command.
//   Each command is decoded in the cycle it is accepted: a row of DEPTH cells
//   compares its positions with the broadcast index and shifts, writes or
//   clears in parallel, so the state is updated at the accepting edge.
//   The result is registered: it is valid in the cycle after acceptance.
//   Throughput is one command per cycle; the single result register lets a
//   new command in whenever that register is empty or being drained.
//   When the receiver stalls, the result holds and in_ready drops until the
//   result transaction completes.
//   Reset clears all entries, the count, the sum and out_valid.
// ----------------------------------------------------------------------------
module indexed_shift_array_with_sum import isasum_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ACT_W-1:0]          action,
  input  logic [IDX_W-1:0]          index,
  input  logic signed [DATA_W-1:0]  value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STAT_W-1:0]         status,
  output logic signed [DATA_W-1:0]  read_value,
  output logic [COUNT_W-1:0]        element_count,
  output logic signed [SUM_W-1:0]   running_sum
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [CMPW-1:0] DEPTH_W = CMPW'(DEPTH);

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W-1:0]  total_next;

  logic                     accept;
  logic [CMPW-1:0]          cnt_w;
  logic [CMPW-1:0]          idx_w;
  logic                     full;
  logic                     empty;
  logic                     idx_lt;
  logic                     idx_le;

  logic [STAT_W-1:0]        st;
  cell_ctrl_t               ctrl;
  cell_ctrl_t               cell_ctrl;
  logic                     add_en;
  logic                     sub_en;
  logic                     ret_rd;
  logic                     cnt_inc;
  logic                     cnt_dec;

  logic signed [DATA_W-1:0] q     [DEPTH];
  logic signed [DATA_W-1:0] sel_q [DEPTH];
  logic signed [DATA_W-1:0] rd_bus;
  logic signed [SUM_W-1:0]  add_term;
  logic signed [SUM_W-1:0]  sub_term;
  logic [CMPW-1:0]          count_out;

  assign accept = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  // Range checks against the current count.
  assign cnt_w  = CMPW'(count);
  assign idx_w  = CMPW'(index);
  assign full   = (cnt_w == DEPTH_W);
  assign empty  = (count == '0);
  assign idx_lt = (idx_w < cnt_w);
  assign idx_le = (idx_w <= cnt_w);

  // Command decode: status, cell operation and bookkeeping updates.
  always_comb begin
    st         = ST_OK;
    ctrl.op    = CELL_NONE;
    ctrl.pos   = POS_W'(index);
    ctrl.limit = POS_W'(count);
    add_en     = 1'b0;
    sub_en     = 1'b0;
    ret_rd     = 1'b0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    unique case (action)
      ACT_READ: begin
        if (!idx_lt) begin
          st = ST_BADIDX;
        end else begin
          ret_rd = 1'b1;
        end
      end
      ACT_WRITE: begin
        if (!idx_lt) begin
          st = ST_BADIDX;
        end else begin
          ctrl.op = CELL_WRITE;
          ret_rd  = 1'b1;
          add_en  = 1'b1;
          sub_en  = 1'b1;
        end
      end
      ACT_INSERT: begin
        if (full) begin
          st = ST_FULL;
        end else if (!idx_le) begin
          st = ST_BADIDX;
        end else begin
          ctrl.op = CELL_INSERT;
          add_en  = 1'b1;
          cnt_inc = 1'b1;
        end
      end
      ACT_APPEND: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ctrl.op  = CELL_INSERT;
          ctrl.pos = POS_W'(count);
          add_en   = 1'b1;
          cnt_inc  = 1'b1;
        end
      end
      ACT_DELETE: begin
        ctrl.limit = POS_W'(count - 1'b1);
        if (empty) begin
          st = ST_EMPTY;
        end else if (!idx_lt) begin
          st = ST_BADIDX;
        end else begin
          ctrl.op = CELL_DELETE;
          ret_rd  = 1'b1;
          sub_en  = 1'b1;
          cnt_dec = 1'b1;
        end
      end
      ACT_DEL_LAST: begin
        ctrl.limit = POS_W'(count - 1'b1);
        ctrl.pos   = POS_W'(count - 1'b1);
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          ctrl.op = CELL_DELETE;
          ret_rd  = 1'b1;
          sub_en  = 1'b1;
          cnt_dec = 1'b1;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // Cells change state only on an accepted command.
  always_comb begin
    cell_ctrl = ctrl;
    if (!accept) begin
      cell_ctrl.op = CELL_NONE;
    end
  end

  // Row of storage cells, each wired to its neighbors; the end cells see zero past the edge.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_left
      assign left_in = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_right
      assign right_in = q[i+1];
    end
    isasum_cell #(
      .POS (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl),
      .value      (value),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (q[i]),
      .sel_data   (sel_q[i])
    );
  end

  // Only the addressed cell drives a nonzero value, so the read is an OR.
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | sel_q[i];
    end
  end

  // Running sum and count updates.
  assign add_term   = add_en ? SUM_W'(value) : '0;
  assign sub_term   = sub_en ? SUM_W'(rd_bus) : '0;
  assign total_next = total + add_term - sub_term;

  always_comb begin
    count_next = count;
    if (cnt_inc) begin
      count_next = count + 1'b1;
    end else if (cnt_dec) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (accept) begin
      count <= count_next;
      total <= total_next;
    end
  end

  // Result register.
  assign count_out = CMPW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= st;
      read_value    <= ret_rd ? rd_bus : '0;
      element_count <= count_out[COUNT_W-1:0];
      running_sum   <= total_next;
    end
  end

endmodule

// ===== tb/sv/isasum_checker.sv =====
// ----------------------------------------------------------------------------
// isasum_checker
// Watches both channels of the indexed shift array, keeps its own copy of the
// entries, count and sum, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module isasum_checker import isasum_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [ACT_W-1:0]          action,
  input  logic [IDX_W-1:0]          index,
  input  logic signed [DATA_W-1:0]  value,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [STAT_W-1:0]         status,
  input  logic signed [DATA_W-1:0]  read_value,
  input  logic [COUNT_W-1:0]        element_count,
  input  logic signed [SUM_W-1:0]   running_sum,
  output int                        mismatches,
  output int                        outstanding,
  output int                        occupancy
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0]        element_count;
    logic signed [SUM_W-1:0]   running_sum;
  } cmd_result_t;

  // Shadow copy of the array state.
  logic signed [DATA_W-1:0] entries [DEPTH];
  logic signed [SUM_W-1:0]  total;
  cmd_result_t              expected_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    occupancy   = 0;
    total       = '0;
    foreach (entries[k]) entries[k] = '0;
  end

  // Sign-extends an entry to the width of the running sum.
  function automatic logic [SUM_W-1:0] widen(input logic [DATA_W-1:0] v);
    return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  // Applies one command to the shadow state and returns the result it gives.
  function automatic cmd_result_t apply_command(input logic [ACT_W-1:0] act,
                                                input logic [IDX_W-1:0] idx,
                                                input logic [DATA_W-1:0] val);
    cmd_result_t r;
    int i;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_READ: begin
        if (idx >= occupancy || idx >= DEPTH) r.status = ST_BADIDX;
        else r.read_value = entries[idx];
      end
      ACT_WRITE: begin
        if (idx >= occupancy || idx >= DEPTH) begin
          r.status = ST_BADIDX;
        end else begin
          r.read_value = entries[idx];
          total = total - widen(entries[idx]) + widen(val);
          entries[idx] = val;
        end
      end
      ACT_INSERT: begin
        // The full check wins over the index check; index == count appends.
        if (occupancy >= DEPTH) begin
          r.status = ST_FULL;
        end else if (idx > occupancy) begin
          r.status = ST_BADIDX;
        end else begin
          for (i = occupancy; i > idx; i--) entries[i] = entries[i-1];
          entries[idx] = val;
          occupancy++;
          total = total + widen(val);
        end
      end
      ACT_APPEND: begin
        if (occupancy >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          entries[occupancy] = val;
          occupancy++;
          total = total + widen(val);
        end
      end
      ACT_DELETE: begin
        // The empty check wins over the index check.
        if (occupancy == 0) begin
          r.status = ST_EMPTY;
        end else if (idx >= occupancy || idx >= DEPTH) begin
          r.status = ST_BADIDX;
        end else begin
          r.read_value = entries[idx];
          for (i = idx; i + 1 < occupancy; i++) entries[i] = entries[i+1];
          entries[occupancy-1] = '0;
          occupancy--;
          total = total - widen(r.read_value);
        end
      end
      ACT_DEL_LAST: begin
        if (occupancy == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_value = entries[occupancy-1];
          entries[occupancy-1] = '0;
          occupancy--;
          total = total - widen(r.read_value);
        end
      end
      default: begin
        // Spare action codes leave the state alone.
      end
    endcase
    r.element_count = occupancy[COUNT_W-1:0];
    r.running_sum   = total;
    return r;
  endfunction

  // Predict on every command transaction and check every result transaction.
  always @(posedge clk) begin
    cmd_result_t want;
    cmd_result_t got;
    if (rst) begin
      foreach (entries[k]) entries[k] = '0;
      total     = '0;
      occupancy = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) expected_results.push_back(apply_command(action, index, value));
      if (out_valid && out_ready) begin
        got.status        = status;
        got.read_value    = read_value;
        got.element_count = element_count;
        got.running_sum   = running_sum;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result transaction: status=%0d read_value=%0d count=%0d sum=%0d",
                     got.status, $signed(got.read_value), got.element_count,
                     $signed(got.running_sum));
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.read_value !== want.read_value ||
              got.element_count !== want.element_count ||
              got.running_sum !== want.running_sum) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result mismatch: expected status=%0d read_value=%0d count=%0d sum=%0d",
                       want.status, $signed(want.read_value), want.element_count,
                       $signed(want.running_sum),
                       "; got status=%0d read_value=%0d count=%0d sum=%0d",
                       got.status, $signed(got.read_value), got.element_count,
                       $signed(got.running_sum));
          end
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== tb/sv/tb_indexed_shift_array_with_sum.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_shift_array_with_sum
// Drives directed and burst-random commands into the indexed shift array
// under varying sender gaps and receiver stalls; the checker compares results.
// ----------------------------------------------------------------------------
module tb_indexed_shift_array_with_sum;
  timeunit 1ns;
  timeprecision 1ps;
  import isasum_pkg::*;

  localparam int DEPTH           = 64;
  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 400;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  // Action codes that the block leaves unused.
  localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

  localparam logic [DATA_W-1:0] DATA_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX} burst_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [ACT_W-1:0]          action = ACT_READ;
  logic [IDX_W-1:0]          index = '0;
  logic signed [DATA_W-1:0]  value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STAT_W-1:0]         status;
  logic signed [DATA_W-1:0]  read_value;
  logic [COUNT_W-1:0]        element_count;
  logic signed [SUM_W-1:0]   running_sum;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int mismatches;
  int outstanding;
  int occupancy;

  indexed_shift_array_with_sum #(.DEPTH(DEPTH)) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .index         (index),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .read_value    (read_value),
    .element_count (element_count),
    .running_sum   (running_sum)
  );

  isasum_checker #(.DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .index         (index),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .read_value    (read_value),
    .element_count (element_count),
    .running_sum   (running_sum),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .occupancy     (occupancy)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Ends the run when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Moves to the next falling edge and lets the sender idle at random.
  task automatic pause();
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Presents one command and holds it until the block accepts it.
  task automatic issue(input logic [ACT_W-1:0] a, input logic [IDX_W-1:0] i,
                       input logic [DATA_W-1:0] v);
    in_valid <= 1'b1;
    action   <= a;
    index    <= i;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_directed(input logic [ACT_W-1:0] a, input logic [IDX_W-1:0] i,
                               input logic [DATA_W-1:0] v);
    pause();
    issue(a, i, v);
  endtask

  // Chooses one command that suits the current burst.
  task automatic pick_command(input burst_t mode, input bit pinned,
                              input logic [DATA_W-1:0] pin_value,
                              output logic [ACT_W-1:0] a, output logic [IDX_W-1:0] i,
                              output logic [DATA_W-1:0] v);
    int roll;
    roll = $urandom_range(99);
    i = IDX_W'($urandom_range(IDX_MAX));
    case ($urandom_range(9))
      0: v = DATA_MAX;
      1: v = DATA_MIN;
      2: v = '0;
      3: v = '1;
      default: v = $urandom;
    endcase
    if (pinned) v = pin_value;
    if (roll < 8) begin
      // Noise: any action code, the spare ones included, at any index.
      a = ACT_W'($urandom_range(ACT_SPARE_7));
    end else begin
      case (mode)
        BURST_FILL:  a = (roll < 50) ? ACT_APPEND : (roll < 82) ? ACT_INSERT :
                         (roll < 91) ? ACT_WRITE : ACT_READ;
        BURST_DRAIN: a = (roll < 45) ? ACT_DELETE : (roll < 75) ? ACT_DEL_LAST :
                         (roll < 88) ? ACT_READ : ACT_WRITE;
        default:     a = ACT_W'($urandom_range(ACT_DEL_LAST));
      endcase
      // Most indexed commands land inside the occupied range, the rest anywhere.
      if ($urandom_range(7) != 0) begin
        if (a == ACT_INSERT)
          i = IDX_W'($urandom_range((occupancy > IDX_MAX) ? IDX_MAX : occupancy));
        else if (occupancy > 0)
          i = IDX_W'($urandom_range(occupancy - 1));
      end
    end
  endtask

  // Random commands in bursts that fill, drain or mix.
  task automatic run_random(input int n_items);
    burst_t mode;
    int done;
    int step;
    int span;
    int tail;
    bit pinned;
    logic [DATA_W-1:0] pin_value;
    logic [ACT_W-1:0] a;
    logic [IDX_W-1:0] i;
    logic [DATA_W-1:0] v;
    done      = 0;
    step      = 0;
    span      = 0;
    tail      = 0;
    mode      = BURST_MIX;
    pinned    = 1'b0;
    pin_value = '0;
    while (done < n_items) begin
      pause();
      // A fill or drain burst runs into the full or empty array and a little past it.
      if ((mode == BURST_FILL && occupancy == DEPTH) || (mode == BURST_DRAIN && occupancy == 0))
        tail--;
      if (step >= span || tail < 0) begin
        mode      = burst_t'($urandom_range(BURST_MIX));
        span      = (mode == BURST_MIX) ? $urandom_range(20, 60) : 250;
        tail      = $urandom_range(2, 6);
        pinned    = ($urandom_range(3) == 0);
        pin_value = $urandom_range(1) ? DATA_MAX : DATA_MIN;
        step      = 0;
      end
      pick_command(mode, pinned, pin_value, a, i, v);
      issue(a, i, v);
      done++;
      step++;
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct  = 30;
    recv_stall_pct = 82;

    // On an empty array all is rejected but the spare codes, which change nothing, and an insert at index zero.
    send_directed(ACT_READ, 0, '0);
    send_directed(ACT_WRITE, 0, DATA_MAX);
    send_directed(ACT_DELETE, 0, '0);
    send_directed(ACT_DEL_LAST, 0, '0);
    send_directed(ACT_INSERT, 1, DATA_MAX);
    send_directed(ACT_SPARE_6, IDX_MAX, '1);
    send_directed(ACT_SPARE_7, IDX_MAX, DATA_MIN);
    send_directed(ACT_INSERT, 0, DATA_MAX);
    // Build a short array, inserting at the front, the end and the middle.
    send_directed(ACT_APPEND, IDX_MAX, DATA_MIN);
    send_directed(ACT_INSERT, 0, '1);
    send_directed(ACT_INSERT, 3, 32'd1);
    send_directed(ACT_INSERT, 2, '0);
    send_directed(ACT_READ, 4, '0);
    send_directed(ACT_READ, 5, '0);
    send_directed(ACT_READ, IDX_MAX, '0);
    send_directed(ACT_WRITE, 1, DATA_MAX);
    send_directed(ACT_WRITE, 5, DATA_MIN);
    // Deletes from the middle, the front and the last index, then past the end.
    send_directed(ACT_DELETE, 2, '0);
    send_directed(ACT_DELETE, 0, '0);
    send_directed(ACT_DELETE, 2, '0);
    send_directed(ACT_DELETE, 3, '0);
    send_directed(ACT_DELETE, IDX_MAX, '0);
    send_directed(ACT_DEL_LAST, 0, '0);
    send_directed(ACT_DEL_LAST, 0, '0);
    send_directed(ACT_DEL_LAST, 0, '0);

    run_random(ITEMS_PER_PHASE);
    send_idle_pct  = 82;
    recv_stall_pct = 30;
    run_random(ITEMS_PER_PHASE);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(ITEMS_PER_PHASE);

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
